// ===== hw/rtl/jst_pkg.sv =====
// Shared types and codes for the job slot table.
package jst_pkg;

   localparam int ID_W  = 22;
   localparam int NUM_W = 16;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_FIND_NUM = 3'd2,
      CMD_FIND_ID  = 3'd3,
      CMD_RECENT   = 3'd4,
      CMD_UPDATE   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [2:0]       command;
      logic [ID_W-1:0]  proc_id;
      logic [NUM_W-1:0] seq_number;
      logic             run_state;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [3:0]       slot_index;
      logic [NUM_W-1:0] found_number;
      logic [ID_W-1:0]  found_id;
      logic             found_state;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  proc_id;
      logic [NUM_W-1:0] seq_number;
      logic             run_state;
   } entry_type;

endpackage

// ===== hw/rtl/job_slot_table.sv =====
// Job slot table: slot allocation, lookup and update over a scanned memory.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------
//   req      | in        | req_valid / req_stall  | req_data (command)
//   rsp      | out       | rsp_valid / rsp_stall  | rsp_data (result)
//
// Order: one item at a time, one slot entry read a cycle.
// Reset: clear the valid marks, the FSM and the result valid; load the counter with one.
// Stalls: a waiting result holds the output register; the next item is taken
// meanwhile and only its reply step waits for the register to empty.
module job_slot_table #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jst_pkg::rsp_type rsp_data
);
   import jst_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
   localparam int CW = $clog2(SLOTS + 1);                 // scan counter width

   // FSM and latched command
   state_type        state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [ID_W-1:0]  key_ff, key_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             st_ff, st_in;

   // scan pipeline
   logic [CW-1:0]    issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;

   // best or first hit so far
   logic             found_ff, found_in;
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   entry_type        hit_ff, hit_in;

   // table state held in flops
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_W-1:0] next_number_ff, next_number_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // FSM outputs
   logic             accept;
   logic             issue_rd;
   logic             do_write;
   logic             load_rsp;

   // memory port
   logic             ram_wr_en;
   entry_type        ram_wr_data;
   entry_type        rd_entry;

   // compare stage
   logic             first_cmd;
   logic             cur_valid;
   logic             match;
   logic             take;
   logic             scan_end;
   entry_type        new_entry;

   jst_slot_ram #(
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (hit_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (issue_rd),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_entry)
   );

   // Compare the entry read last cycle against the latched command.
   always_comb begin
      first_cmd = (cmd_ff != CMD_RECENT);
      cur_valid = valid_ff[rd_idx_ff];
      case (cmd_ff)
         CMD_INSERT:
            match = !cur_valid;
         CMD_REMOVE, CMD_FIND_ID, CMD_UPDATE:
            match = cur_valid && (rd_entry.proc_id == key_ff);
         CMD_FIND_NUM:
            match = cur_valid && (rd_entry.seq_number == num_ff);
         CMD_RECENT:
            match = cur_valid && (!found_ff || (rd_entry.seq_number > hit_ff.seq_number));
         default:
            match = 1'b0;
      endcase
      // ignore reads still in flight once a first-match command has its hit
      take      = (state_ff == ST_SCAN) && pend_ff && match && !(found_ff && first_cmd);
      scan_end  = (found_ff && first_cmd) || ((issue_ff == CW'(SLOTS)) && !pend_ff);
      new_entry.proc_id    = key_ff;
      new_entry.seq_number = next_number_ff;
      new_entry.run_state  = st_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SCAN;
         ST_SCAN:  if (scan_end) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_REPLY;
         ST_REPLY: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // FSM outputs.
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      issue_rd  = 1'b0;
      do_write  = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_SCAN:  issue_rd = (issue_ff != CW'(SLOTS)) && !(found_ff && first_cmd);
         ST_WRITE: do_write = found_ff;
         ST_REPLY: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      num_in         = num_ff;
      st_in          = st_ff;
      issue_in       = issue_ff;
      pend_in        = issue_rd;
      rd_idx_in      = issue_rd ? issue_ff[IW-1:0] : rd_idx_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_in         = hit_ff;
      valid_in       = valid_ff;
      next_number_in = next_number_ff;
      ram_wr_en      = 1'b0;
      ram_wr_data    = hit_ff;
      rsp_data_in    = rsp_data_ff;

      // latch the command and restart the scan
      if (accept) begin
         cmd_in   = req_data.command;
         key_in   = req_data.proc_id;
         num_in   = req_data.seq_number;
         st_in    = req_data.run_state;
         issue_in = '0;
         found_in = 1'b0;
      end

      if (issue_rd) begin
         issue_in = issue_ff + CW'(1);
      end

      if (take) begin
         found_in   = 1'b1;
         hit_idx_in = rd_idx_ff;
         hit_in     = (cmd_ff == CMD_INSERT) ? new_entry : rd_entry;
      end

      // commit the change to the table
      if (do_write) begin
         case (cmd_ff)
            CMD_INSERT: begin
               valid_in[hit_idx_ff] = 1'b1;
               ram_wr_en            = 1'b1;
               next_number_in       = next_number_ff + NUM_W'(1);
            end
            CMD_REMOVE: begin
               valid_in[hit_idx_ff] = 1'b0;
            end
            CMD_UPDATE: begin
               ram_wr_en             = 1'b1;
               ram_wr_data.run_state = st_ff;
               hit_in.run_state      = st_ff;
            end
            default: begin
               ram_wr_en = 1'b0;
            end
         endcase
      end

      // build the result item
      if (load_rsp) begin
         if (found_ff) begin
            rsp_data_in.status       = STS_OK;
            rsp_data_in.slot_index   = 4'(hit_idx_ff);
            rsp_data_in.found_number = hit_ff.seq_number;
            rsp_data_in.found_id     = hit_ff.proc_id;
            rsp_data_in.found_state  = hit_ff.run_state;
         end else begin
            rsp_data_in.status       = (cmd_ff == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
            rsp_data_in.slot_index   = '0;
            rsp_data_in.found_number = '0;
            rsp_data_in.found_id     = '0;
            rsp_data_in.found_state  = 1'b0;
         end
      end

      // hold the result until taken
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         issue_ff       <= '0;
         valid_ff       <= '0;
         next_number_ff <= NUM_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         issue_ff       <= issue_in;
         valid_ff       <= valid_in;
         next_number_ff <= next_number_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      num_ff      <= num_in;
      st_ff       <= st_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/jst_slot_ram.sv =====
// Slot entry memory: one write port, one registered read port.
module jst_slot_ram #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  jst_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output jst_pkg::entry_type  rd_data
);
   import jst_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the job slot table: shadow table, scoreboard and drivers.
`timescale 1ns / 100ps

module testbench;
   import jst_pkg::*;

   localparam int SLOTS       = 16;
   // A hang is the only way to get here
   localparam int CYCLE_LIMIT = 10_000_000;
   // Insert and remove pairs run on slot 0 to push the counter ahead
   localparam int CHURN_LAPS  = 8;
   // Command codes outside the defined set; the block must answer them with not found
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   // Key kept for the sequence counter churn, so that each remove finds the churned slot
   localparam logic [ID_W-1:0] CHURN_ID = 22'h2AAAAA;

   // Shadow of the slot table: predicts each reply as the command is accepted and
   // holds the predictions in order until the block answers.
   class slot_table_scoreboard;
      bit               live   [SLOTS];
      logic [ID_W-1:0]  owner  [SLOTS];
      logic [NUM_W-1:0] number [SLOTS];
      logic             halted [SLOTS];
      logic [NUM_W-1:0] next_number;
      rsp_type          awaited [$];
      int               mismatches;
      int               replies;
      int               ok_seen;
      int               full_seen;
      int               miss_seen;
      int               wraps;

      function void clear();
         foreach (live[i]) live[i] = 1'b0;
         next_number = 1;
         awaited.delete();
         mismatches  = 0;
         replies     = 0;
         ok_seen     = 0;
         full_seen   = 0;
         miss_seen   = 0;
         wraps       = 0;
      endfunction

      function int first_with_id(logic [ID_W-1:0] key);
         int i;
         for (i = 0; i < SLOTS; i++)
            if (live[i] && owner[i] == key) return i;
         return -1;
      endfunction

      // Random occupied slot, or -1 when the table is empty
      function int any_live();
         int picks[$];
         int i;
         for (i = 0; i < SLOTS; i++)
            if (live[i]) picks.push_back(i);
         if (picks.size() == 0) return -1;
         return picks[$urandom_range(0, picks.size() - 1)];
      endfunction

      function void note_command(req_type cmd);
         rsp_type want;
         int      hit;
         int      i;
         want        = '0;
         want.status = STS_NOT_FOUND;
         hit         = -1;
         case (cmd.command)
            CMD_INSERT: begin
               for (i = 0; i < SLOTS && hit < 0; i++)
                  if (!live[i]) hit = i;
               if (hit < 0) begin
                  want.status = STS_FULL;
               end else begin
                  live[hit]   = 1'b1;
                  owner[hit]  = cmd.proc_id;
                  halted[hit] = cmd.run_state;
                  number[hit] = next_number;
                  if (next_number == '1) wraps++;
                  next_number++;
               end
            end
            CMD_REMOVE:   hit = first_with_id(cmd.proc_id);
            CMD_FIND_NUM: begin
               for (i = 0; i < SLOTS && hit < 0; i++)
                  if (live[i] && number[i] == cmd.seq_number) hit = i;
            end
            CMD_FIND_ID:  hit = first_with_id(cmd.proc_id);
            CMD_RECENT: begin
               // plain unsigned compare, lowest index wins a tie
               for (i = 0; i < SLOTS; i++)
                  if (live[i] && (hit < 0 || number[i] > number[hit])) hit = i;
            end
            CMD_UPDATE: begin
               hit = first_with_id(cmd.proc_id);
               if (hit >= 0) halted[hit] = cmd.run_state;
            end
            default: ;
         endcase
         if (hit >= 0) begin
            want.status       = STS_OK;
            want.slot_index   = 4'(hit);
            want.found_number = number[hit];
            want.found_id     = owner[hit];
            want.found_state  = halted[hit];
            // remove reports the contents as they were, then frees the slot
            if (cmd.command == CMD_REMOVE) live[hit] = 1'b0;
         end
         case (want.status)
            STS_OK:   ok_seen++;
            STS_FULL: full_seen++;
            default:  miss_seen++;
         endcase
         awaited.push_back(want);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         if (mismatches <= 30)
            $display("[%0t] reply %0d: %s is %h, predicted %h", $time, replies, what, got, want);
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         replies++;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected reply", 64'(got), 64'(0));
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
         if (got.found_number !== want.found_number)
            report_mismatch("found_number", 64'(got.found_number), 64'(want.found_number));
         if (got.found_id !== want.found_id)
            report_mismatch("found_id", 64'(got.found_id), 64'(want.found_id));
         if (got.found_state !== want.found_state)
            report_mismatch("found_state", 64'(got.found_state), 64'(want.found_state));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   slot_table_scoreboard ledger;

   // Knobs shared by the sender and the receiver
   bit quiet_source  = 1'b0;   // no gaps between items
   bit quiet_sink    = 1'b0;   // never stall replies unless a forced hold-off runs
   int hold_off_left = 0;      // cycles of forced back-pressure still to run
   int items_sent    = 0;
   int cycles        = 0;

   job_slot_table #(
      .SLOTS (SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one command, hold it until the block takes it, then note the
   // prediction and idle for a random gap. Valid stays high into the next
   // item when there is no gap, so it is never dropped and raised in one step.
   task automatic offer(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                        input logic [NUM_W-1:0] num, input logic st);
      req_type item;
      int      gap;
      item.command    = cmd;
      item.proc_id    = id;
      item.seq_number = num;
      item.run_state  = st;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      ledger.note_command(item);
      items_sent++;
      gap = quiet_source ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every predicted reply has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
   endtask

   // Reply side: check each accepted item against the oldest prediction,
   // then choose the stall for the next cycle.
   initial begin : reply_sink
      int run_left;
      bit stalling;
      run_left = 0;
      stalling = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) ledger.check_reply(rsp_data);
         if (hold_off_left > 0) begin
            // long forced hold-off: the block must fill up and stall its input
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_sink) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               stalling = ($urandom_range(0, 99) < 35);
               if (stalling)
                  run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 50)
                                                         : $urandom_range(1, 3);
               else
                  run_left = $urandom_range(1, 10);
            end
            run_left--;
            rsp_stall <= stalling;
         end
      end
   end

   // Watchdog: a stuck handshake ends the run here
   initial begin : watchdog
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d replies still outstanding",
               cycles, ledger.awaited.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [2:0]       cmd;
      logic [ID_W-1:0]  id;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] target;
      logic [ID_W-1:0]  id_pool [4];
      logic             st;
      int               seg;
      int               weight;
      int               roll;
      int               pick;

      ledger = new();
      ledger.clear();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every command on an empty table, the spare codes, then a
      // duplicate key, update, remove and lookups by both keys.
      offer(CMD_RECENT,   '0, '0, 1'b0);
      offer(CMD_FIND_ID,  '1, '1, 1'b1);
      offer(CMD_FIND_NUM, '0, 16'd1, 1'b0);
      offer(CMD_REMOVE,   '0, '0, 1'b0);
      offer(CMD_UPDATE,   '0, '0, 1'b1);
      offer(CMD_SPARE_6,  '1, '1, 1'b1);
      offer(CMD_SPARE_7,  '1, '1, 1'b1);
      offer(CMD_INSERT,   '0, '1, 1'b0);
      offer(CMD_INSERT,   '1, '0, 1'b1);
      offer(CMD_INSERT,   '1, '1, 1'b0);      // same key again, next slot up
      offer(CMD_FIND_ID,  '1, '0, 1'b0);
      offer(CMD_UPDATE,   '1, '0, 1'b0);
      offer(CMD_FIND_NUM, '0, 16'd3, 1'b0);
      offer(CMD_FIND_NUM, '1, '1, 1'b1);      // number never handed out
      offer(CMD_REMOVE,   '1, '0, 1'b0);
      offer(CMD_FIND_ID,  '1, '0, 1'b0);      // now finds the duplicate
      offer(CMD_INSERT,   22'h155555, 16'h5555, 1'b1);
      offer(CMD_RECENT,   '1, '1, 1'b1);
      offer(CMD_UPDATE,   CHURN_ID, '0, 1'b1);
      offer(CMD_SPARE_6,  '0, '0, 1'b0);

      // Fill the table; the last few inserts find it full
      repeat (SLOTS) offer(CMD_INSERT, ID_W'($urandom()), NUM_W'($urandom()),
                           1'($urandom_range(0, 1)));

      // Free slot 0 and churn it back to back so that slot 0 keeps taking the
      // newest number, then look up a number held in the middle of the table.
      offer(CMD_REMOVE, ledger.owner[0], '0, 1'b0);
      quiet_source = 1'b1;
      quiet_sink   = 1'b1;
      target       = ledger.number[SLOTS / 2];
      repeat (CHURN_LAPS) begin
         offer(CMD_INSERT, CHURN_ID, '0, 1'b0);
         offer(CMD_REMOVE, CHURN_ID, '0, 1'b0);
      end
      offer(CMD_INSERT,   CHURN_ID, '0, 1'b1);
      offer(CMD_FIND_NUM, '0, target, 1'b0);   // mid-table slot, not the churned one
      offer(CMD_RECENT,   '0, '0, 1'b0);
      quiet_source = 1'b0;
      quiet_sink   = 1'b0;
      drain();

      // Random part: segments that lean towards filling or emptying the table,
      // with keys mostly drawn from live slots so that lookups hit.
      id_pool[0] = '0;
      id_pool[1] = '1;
      id_pool[2] = 22'h155555;
      for (seg = 0; seg < 15; seg++) begin
         case ($urandom_range(0, 2))
            0:       weight = 12;
            1:       weight = 32;
            default: weight = 60;
         endcase
         id_pool[3]   = ID_W'($urandom());
         quiet_source = ($urandom_range(0, 4) == 0);
         quiet_sink   = ($urandom_range(0, 4) == 0);
         if (seg == 5) begin
            // stop taking replies for a long stretch while items keep coming
            quiet_source  = 1'b1;
            hold_off_left = 300;
         end
         if (seg == 10) drain();
         repeat (40) begin
            roll = $urandom_range(0, 99);
            if (roll < weight) begin
               cmd = CMD_INSERT;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 24)      cmd = CMD_REMOVE;
               else if (roll < 42) cmd = CMD_FIND_NUM;
               else if (roll < 62) cmd = CMD_FIND_ID;
               else if (roll < 76) cmd = CMD_RECENT;
               else if (roll < 96) cmd = CMD_UPDATE;
               else if (roll < 98) cmd = CMD_SPARE_6;
               else                cmd = CMD_SPARE_7;
            end
            id   = ID_W'($urandom());
            num  = NUM_W'($urandom());
            st   = 1'($urandom_range(0, 1));
            pick = ledger.any_live();
            roll = $urandom_range(0, 99);
            if (roll < 65 && pick >= 0) id = ledger.owner[pick];
            else if (roll < 85)         id = id_pool[$urandom_range(0, 3)];
            if (cmd == CMD_FIND_NUM && pick >= 0 && $urandom_range(0, 3) != 0)
               num = ledger.number[pick];
            offer(cmd, id, num, st);
         end
      end

      // Wind down: wait for the last replies, then watch for strays
      quiet_sink = 1'b0;
      drain();
      repeat (3 * (SLOTS + 4)) @(posedge clock);

      $display("Run summary: %0d commands, %0d replies (%0d hits, %0d full, %0d misses),",
               items_sent, ledger.replies, ledger.ok_seen, ledger.full_seen,
               ledger.miss_seen);
      $display("sequence counter wrapped %0d time(s), %0d mismatch(es) over %0d cycles.",
               ledger.wraps, ledger.mismatches, cycles);
      if (ledger.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/jst_pkg.sv
hw/rtl/jst_slot_ram.sv
hw/rtl/job_slot_table.sv
tb/testbench.sv
